FILE: design/desc_pkg.sv
// Shared types, codes and constants of the event stream checker.
`default_nettype none
package desc_pkg;

    localparam int NUM_CHANNELS_DEF = 7;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_EXPECTED   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_CHANNEL = 1'd1;

    localparam logic [31:0] CHANNELS_RESET = 32'd7;
    localparam logic [15:0] SAMPLES_RESET  = 16'd1024;

    localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
    localparam logic [4:0]  SYNC_RUN_LEN = 5'd20;
    localparam logic [10:0] SYNC_LIMIT   = 11'd1000;
    localparam logic [31:0] MARKER_WORD  = 32'hCCCC_CCCC;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_SYNC       = 3'd1;
    localparam logic [2:0] ERR_MARKER     = 3'd2;
    localparam logic [2:0] ERR_EVENT_NUM  = 3'd3;
    localparam logic [2:0] ERR_CHANNELS   = 3'd4;
    localparam logic [2:0] ERR_LENGTH     = 3'd5;
    localparam logic [2:0] ERR_RANGE      = 3'd6;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_MARK,
        PH_EVNO,
        PH_STMP,
        PH_CHAN,
        PH_LEN,
        PH_SAMP
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic        fatal;
        logic [31:0] event_number;
        logic [31:0] time_stamp;
        logic [2:0]  channel;
        logic [15:0] sample_index;
        logic [13:0] sample_value;
        logic        last_of_event;
    } result_t;

endpackage
`default_nettype wire

FILE: design/desc_if.sv
// Stream interfaces: raw byte channel and result channel.
`default_nettype none
interface desc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface desc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic        fatal;
    logic [31:0] event_number;
    logic [31:0] time_stamp;
    logic [2:0]  channel;
    logic [15:0] sample_index;
    logic [13:0] sample_value;
    logic        last_of_event;

    modport source (
        output valid, output kind, output error_code, output fatal,
        output event_number, output time_stamp, output channel,
        output sample_index, output sample_value, output last_of_event,
        input ready
    );
    modport sink (
        input valid, input kind, input error_code, input fatal,
        input event_number, input time_stamp, input channel,
        input sample_index, input sample_value, input last_of_event,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/daq_event_stream_checker.sv
// Byte-serial event stream checker: sync hunt, header checks, sample emission.
//
// Usage:
//   stream : byte channel (valid/ready), one raw byte of the run stream per word.
//   result : result channel (valid/ready), at most one result word per input byte:
//            a sample, an accepted event header, or an error report.
//   cfg_*  : plain write port; index 0 = channels_expected, 1 = samples_per_channel.
//            Write only while the block is idle.
// Result path: a byte that produces a result has it registered into the output
//   register, or into the skid register while the output word is stalled.
// Throughput: one byte per clock, sustained, as long as results are taken.
//   The result side holds two words (output register plus skid register), so a
//   byte is still accepted while one finished result waits; stream.ready drops
//   only when both are full.
// Reset (rst_n low, async): parser back to the sync hunt, event counter 0,
//   registers to 7 channels and 1024 samples per channel, result queue empty.
// Fatal errors (sync timeout, event number, channel count, length) halt the
//   parser: bytes are still taken but ignored until the next reset.
// Receiver stall: results queue in the two-word stage; input then stalls.
`default_nettype none
module daq_event_stream_checker #(
    parameter int NUM_CHANNELS = desc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    desc_byte_if.sink                             stream,
    desc_result_if.source                         result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [desc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [desc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [31:0] chan_exp_reg;
    logic [15:0] spc_reg;

    // parser state
    desc_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  sync_run_reg, sync_run_next;
    logic [10:0] search_count_reg, search_count_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [23:0] word_buf_reg, word_buf_next;
    logic [31:0] expected_event_reg, expected_event_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [2:0]  chan_idx_reg, chan_idx_next;
    logic [15:0] samp_idx_reg, samp_idx_next;
    logic        halted_reg, halted_next;

    // two-word result queue: output register and skid register
    desc_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    desc_pkg::result_t res;
    logic              has_res;

    logic        accept;
    logic        active;
    logic [7:0]  b;
    logic [4:0]  sync_run_inc;
    logic [10:0] search_inc;
    logic        sync_timeout;
    logic        sync_found;
    logic [31:0] word;
    logic        word_done;
    logic        half_done;
    logic [15:0] samp_word;
    logic        chan_end;
    logic        chan_last;
    logic        evt_last;
    logic        take;

    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && stream.ready;
    assign active       = accept && !halted_reg;
    assign b            = stream.data_byte;

    assign sync_run_inc = (b == desc_pkg::SYNC_BYTE) ? sync_run_reg + 5'd1 : 5'd0;
    assign search_inc   = search_count_reg + 11'd1;
    assign sync_timeout = search_inc > desc_pkg::SYNC_LIMIT;
    assign sync_found   = sync_run_inc >= desc_pkg::SYNC_RUN_LEN;

    // header words are little endian; the last byte completes the word
    assign word      = {b, word_buf_reg};
    assign word_done = byte_pos_reg == 2'd3;
    assign half_done = byte_pos_reg != 2'd0;
    assign samp_word = {b, word_buf_reg[7:0]};

    // channel ends once samp_idx + 1 reaches the live length register
    assign chan_end  = ({1'b0, samp_idx_reg} + 17'd1) >= {1'b0, spc_reg};
    assign chan_last = ({1'b0, chan_idx_reg} + 4'd1) >= 4'(NUM_CHANNELS);
    assign evt_last  = chan_end && chan_last;

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        if (active)
        begin
            case (phase_reg)
                desc_pkg::PH_SYNC:
                begin
                    if (!sync_timeout && sync_found)
                        phase_next = desc_pkg::PH_MARK;
                end
                desc_pkg::PH_MARK:
                begin
                    if (word_done && word == desc_pkg::MARKER_WORD)
                        phase_next = desc_pkg::PH_EVNO;
                end
                desc_pkg::PH_EVNO:
                begin
                    if (word_done && word == expected_event_reg)
                        phase_next = desc_pkg::PH_STMP;
                end
                desc_pkg::PH_STMP:
                begin
                    if (word_done)
                        phase_next = desc_pkg::PH_CHAN;
                end
                desc_pkg::PH_CHAN:
                begin
                    if (word_done && word == chan_exp_reg)
                        phase_next = desc_pkg::PH_LEN;
                end
                desc_pkg::PH_LEN:
                begin
                    if (word_done && word == {16'd0, spc_reg})
                        phase_next = (spc_reg == 16'd0) ? desc_pkg::PH_MARK
                                                        : desc_pkg::PH_SAMP;
                end
                desc_pkg::PH_SAMP:
                begin
                    if (half_done && evt_last)
                        phase_next = desc_pkg::PH_MARK;
                end
                default:
                begin
                    phase_next = desc_pkg::PH_MARK;
                end
            endcase
        end
    end

    // datapath and result word
    always_comb
    begin
        sync_run_next       = sync_run_reg;
        search_count_next   = search_count_reg;
        byte_pos_next       = byte_pos_reg;
        word_buf_next       = word_buf_reg;
        expected_event_next = expected_event_reg;
        stamp_next          = stamp_reg;
        chan_idx_next       = chan_idx_reg;
        samp_idx_next       = samp_idx_reg;
        halted_next         = halted_reg;
        res                 = '0;
        has_res             = 1'b0;

        if (active)
        begin
            case (phase_reg)
                desc_pkg::PH_SYNC:
                begin
                    sync_run_next     = sync_run_inc;
                    search_count_next = search_inc;
                    if (sync_timeout)
                    begin
                        halted_next    = 1'b1;
                        has_res        = 1'b1;
                        res.kind       = desc_pkg::KIND_ERROR;
                        res.error_code = desc_pkg::ERR_SYNC;
                        res.fatal      = 1'b1;
                    end
                    else if (sync_found)
                    begin
                        byte_pos_next = 2'd0;
                        word_buf_next = 24'd0;
                    end
                end
                desc_pkg::PH_SAMP:
                begin
                    if (!half_done)
                    begin
                        word_buf_next = {16'd0, b};
                        byte_pos_next = 2'd1;
                    end
                    else
                    begin
                        byte_pos_next = 2'd0;
                        word_buf_next = 24'd0;
                        if (chan_end)
                        begin
                            samp_idx_next = 16'd0;
                            chan_idx_next = chan_idx_reg + 3'd1;
                        end
                        else
                        begin
                            samp_idx_next = samp_idx_reg + 16'd1;
                        end
                        if (evt_last)
                        begin
                            chan_idx_next = 3'd0;
                            samp_idx_next = 16'd0;
                        end
                        has_res           = 1'b1;
                        res.event_number  = expected_event_reg - 32'd1;
                        res.time_stamp    = stamp_reg;
                        res.channel       = chan_idx_reg;
                        res.sample_index  = samp_idx_reg;
                        res.last_of_event = evt_last;
                        // value of 16384 or more: report in place of the sample
                        if (samp_word[15:14] != 2'd0)
                        begin
                            res.kind       = desc_pkg::KIND_ERROR;
                            res.error_code = desc_pkg::ERR_RANGE;
                        end
                        else
                        begin
                            res.kind         = desc_pkg::KIND_SAMPLE;
                            res.sample_value = samp_word[13:0];
                        end
                    end
                end
                default:
                begin
                    if (!word_done)
                    begin
                        word_buf_next = word_buf_reg | (24'(b) << {byte_pos_reg, 3'b000});
                        byte_pos_next = byte_pos_reg + 2'd1;
                    end
                    else
                    begin
                        byte_pos_next = 2'd0;
                        word_buf_next = 24'd0;
                        case (phase_reg)
                            desc_pkg::PH_MARK:
                            begin
                                if (word != desc_pkg::MARKER_WORD)
                                begin
                                    has_res          = 1'b1;
                                    res.kind         = desc_pkg::KIND_ERROR;
                                    res.error_code   = desc_pkg::ERR_MARKER;
                                    res.event_number = expected_event_reg;
                                end
                            end
                            desc_pkg::PH_EVNO:
                            begin
                                if (word != expected_event_reg)
                                begin
                                    halted_next      = 1'b1;
                                    has_res          = 1'b1;
                                    res.kind         = desc_pkg::KIND_ERROR;
                                    res.error_code   = desc_pkg::ERR_EVENT_NUM;
                                    res.fatal        = 1'b1;
                                    res.event_number = expected_event_reg;
                                end
                            end
                            desc_pkg::PH_STMP:
                            begin
                                stamp_next = word;
                            end
                            desc_pkg::PH_CHAN:
                            begin
                                if (word != chan_exp_reg)
                                begin
                                    halted_next      = 1'b1;
                                    has_res          = 1'b1;
                                    res.kind         = desc_pkg::KIND_ERROR;
                                    res.error_code   = desc_pkg::ERR_CHANNELS;
                                    res.fatal        = 1'b1;
                                    res.event_number = expected_event_reg;
                                    res.time_stamp   = stamp_reg;
                                end
                            end
                            desc_pkg::PH_LEN:
                            begin
                                has_res          = 1'b1;
                                res.event_number = expected_event_reg;
                                res.time_stamp   = stamp_reg;
                                if (word != {16'd0, spc_reg})
                                begin
                                    halted_next    = 1'b1;
                                    res.kind       = desc_pkg::KIND_ERROR;
                                    res.error_code = desc_pkg::ERR_LENGTH;
                                    res.fatal      = 1'b1;
                                end
                                else
                                begin
                                    res.kind            = desc_pkg::KIND_HEADER;
                                    res.last_of_event   = spc_reg == 16'd0;
                                    expected_event_next = expected_event_reg + 32'd1;
                                    chan_idx_next       = 3'd0;
                                    samp_idx_next       = 16'd0;
                                end
                            end
                            default:
                            begin
                                has_res = 1'b0;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_exp_reg       <= desc_pkg::CHANNELS_RESET;
            spc_reg            <= desc_pkg::SAMPLES_RESET;
            phase_reg          <= desc_pkg::PH_SYNC;
            sync_run_reg       <= 5'd0;
            search_count_reg   <= 11'd0;
            byte_pos_reg       <= 2'd0;
            word_buf_reg       <= 24'd0;
            expected_event_reg <= 32'd0;
            stamp_reg          <= 32'd0;
            chan_idx_reg       <= 3'd0;
            samp_idx_reg       <= 16'd0;
            halted_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    desc_pkg::CFG_CHANNELS_EXPECTED:   chan_exp_reg <= cfg_data;
                    desc_pkg::CFG_SAMPLES_PER_CHANNEL: spc_reg      <= cfg_data[15:0];
                    default:                           spc_reg      <= spc_reg;
                endcase
            end
            phase_reg          <= phase_next;
            sync_run_reg       <= sync_run_next;
            search_count_reg   <= search_count_next;
            byte_pos_reg       <= byte_pos_next;
            word_buf_reg       <= word_buf_next;
            expected_event_reg <= expected_event_next;
            stamp_reg          <= stamp_next;
            chan_idx_reg       <= chan_idx_next;
            samp_idx_reg       <= samp_idx_next;
            halted_reg         <= halted_next;
        end
    end

    // result queue: skid only fills while the output word is stalled
    assign take = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (has_res)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (has_res)
        begin
            if (out_valid_reg && !take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_reg.kind;
    assign result.error_code    = out_reg.error_code;
    assign result.fatal         = out_reg.fatal;
    assign result.event_number  = out_reg.event_number;
    assign result.time_stamp    = out_reg.time_stamp;
    assign result.channel       = out_reg.channel;
    assign result.sample_index  = out_reg.sample_index;
    assign result.sample_value  = out_reg.sample_value;
    assign result.last_of_event = out_reg.last_of_event;

endmodule
`default_nettype wire

FILE: design/desc_checker.sv
// Port-level assertions for the event stream checker, bound to the top level.
`default_nettype none
module desc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] kind,
    input wire logic [2:0] error_code,
    input wire logic       fatal
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // input stalls only when a result word is already waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result side");

    // a fatal report is the last word before reset
    a_fatal_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && fatal |=> !out_valid)
        else $error("result after fatal report");

    // error reports carry a code, others none; fatal only on halting codes
    a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == desc_pkg::KIND_ERROR) == (error_code != desc_pkg::ERR_NONE))
                      && (!fatal || error_code == desc_pkg::ERR_SYNC
                          || error_code == desc_pkg::ERR_EVENT_NUM
                          || error_code == desc_pkg::ERR_CHANNELS
                          || error_code == desc_pkg::ERR_LENGTH))
        else $error("error code inconsistent with kind");

endmodule

bind daq_event_stream_checker desc_checker u_desc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (stream.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .kind       (result.kind),
    .error_code (result.error_code),
    .fatal      (result.fatal)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench of the event stream checker: byte streams in, result words checked.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH       = desc_pkg::NUM_CHANNELS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 820;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_AFTER   = 100;      // result words before the long receiver stall
    localparam int HOLD_LEN     = 300;
    localparam int SYNC_NOISE   = 230;      // noise ahead of the 20 sync bytes

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [desc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [desc_pkg::CFG_DATA_W-1:0]  cfg_data;

    desc_byte_if   stream_if();
    desc_result_if result_if();

    daq_event_stream_checker #(.NUM_CHANNELS(NUM_CH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stream parser mirror: own copy of parser state and registers
    // ------------------------------------------------------------------
    desc_pkg::phase_t prs_phase;
    int unsigned      sync_len;
    int unsigned      hunt_count;
    logic [1:0]       byte_idx;
    logic [23:0]      word_acc;
    logic [31:0]      next_event;
    logic [31:0]      cur_stamp;
    logic [2:0]       cur_chan;
    logic [15:0]      cur_samp;
    bit               stopped;
    logic [31:0]      cfg_channels;
    logic [15:0]      cfg_samples;

    desc_pkg::result_t pending_results[$];   // predicted result words, oldest first
    logic [7:0]        byte_backlog[$];      // bytes waiting for the driver
    logic [15:0]       sample_plan[$];       // fixed sample values used before random ones

    int send_idle_pct = IDLE_PCT;
    int take_idle_pct = IDLE_PCT;

    int unsigned bytes_taken, bytes_queued, words_checked, mismatches, cycle_count;
    int unsigned samples_seen, headers_seen, range_seen, marker_seen;
    logic [2:0]  fatal_code_seen;
    logic [31:0] events_built;         // event number the next good header carries

    task automatic add_byte(input logic [7:0] b);
        byte_backlog.insert(byte_backlog.size(), b);
    endtask

    // Advance the mirror by one accepted byte; queue the result word it causes, if any.
    task automatic parse_byte(input logic [7:0] b);
        logic [31:0]       w;
        logic [15:0]       s16;
        desc_pkg::result_t r;
        bit                produced;
        bit                chan_end;
        bit                last_word;
        r = '0;
        produced = 1'b0;
        if (stopped)
            return;
        if (prs_phase == desc_pkg::PH_SYNC)
        begin
            sync_len = (b == desc_pkg::SYNC_BYTE) ? sync_len + 1 : 0;
            hunt_count++;
            if (hunt_count > desc_pkg::SYNC_LIMIT)
            begin
                // hunt ran out: fatal, even if this byte would have completed the run
                stopped = 1'b1;
                r.kind = desc_pkg::KIND_ERROR;
                r.error_code = desc_pkg::ERR_SYNC;
                r.fatal = 1'b1;
                produced = 1'b1;
            end
            else if (sync_len >= desc_pkg::SYNC_RUN_LEN)
            begin
                prs_phase = desc_pkg::PH_MARK;
                byte_idx = '0;
                word_acc = '0;
            end
        end
        else if (prs_phase == desc_pkg::PH_SAMP)
        begin
            if (byte_idx == 2'd0)
            begin
                word_acc = 24'(b);
                byte_idx = 2'd1;
            end
            else
            begin
                s16 = {b, word_acc[7:0]};
                byte_idx = '0;
                word_acc = '0;
                // channel end uses the live register, so a shrink mid-event ends it early
                chan_end = (int'(cur_samp) + 1 >= int'(cfg_samples));
                last_word = chan_end && (int'(cur_chan) + 1 >= NUM_CH);
                r.event_number = next_event - 32'd1;
                r.time_stamp = cur_stamp;
                r.channel = cur_chan;
                r.sample_index = cur_samp;
                r.last_of_event = last_word;
                if (s16 >= 16'd16384)
                begin
                    r.kind = desc_pkg::KIND_ERROR;
                    r.error_code = desc_pkg::ERR_RANGE;
                end
                else
                begin
                    r.kind = desc_pkg::KIND_SAMPLE;
                    r.sample_value = s16[13:0];
                end
                if (chan_end)
                begin
                    cur_samp = '0;
                    cur_chan = cur_chan + 3'd1;
                end
                else
                    cur_samp = cur_samp + 16'd1;
                if (last_word)
                begin
                    prs_phase = desc_pkg::PH_MARK;
                    cur_chan = '0;
                    cur_samp = '0;
                end
                produced = 1'b1;
            end
        end
        else if (byte_idx < 2'd3)
        begin
            word_acc = word_acc | (24'(b) << (8 * byte_idx));
            byte_idx = byte_idx + 2'd1;
        end
        else
        begin
            w = {b, word_acc};
            byte_idx = '0;
            word_acc = '0;
            case (prs_phase)
                desc_pkg::PH_MARK:
                    if (w == desc_pkg::MARKER_WORD)
                        prs_phase = desc_pkg::PH_EVNO;
                    else
                    begin
                        r.kind = desc_pkg::KIND_ERROR;
                        r.error_code = desc_pkg::ERR_MARKER;
                        r.event_number = next_event;
                        produced = 1'b1;
                    end
                desc_pkg::PH_EVNO:
                    if (w != next_event)
                    begin
                        stopped = 1'b1;
                        r.kind = desc_pkg::KIND_ERROR;
                        r.error_code = desc_pkg::ERR_EVENT_NUM;
                        r.fatal = 1'b1;
                        r.event_number = next_event;
                        produced = 1'b1;
                    end
                    else
                        prs_phase = desc_pkg::PH_STMP;
                desc_pkg::PH_STMP:
                begin
                    cur_stamp = w;
                    prs_phase = desc_pkg::PH_CHAN;
                end
                desc_pkg::PH_CHAN:
                    if (w != cfg_channels)
                    begin
                        stopped = 1'b1;
                        r.kind = desc_pkg::KIND_ERROR;
                        r.error_code = desc_pkg::ERR_CHANNELS;
                        r.fatal = 1'b1;
                        r.event_number = next_event;
                        r.time_stamp = cur_stamp;
                        produced = 1'b1;
                    end
                    else
                        prs_phase = desc_pkg::PH_LEN;
                desc_pkg::PH_LEN:
                begin
                    r.event_number = next_event;
                    r.time_stamp = cur_stamp;
                    produced = 1'b1;
                    if (w != {16'h0, cfg_samples})
                    begin
                        stopped = 1'b1;
                        r.kind = desc_pkg::KIND_ERROR;
                        r.error_code = desc_pkg::ERR_LENGTH;
                        r.fatal = 1'b1;
                    end
                    else
                    begin
                        // zero-length event: the header word closes the event
                        r.kind = desc_pkg::KIND_HEADER;
                        r.last_of_event = (cfg_samples == 16'd0);
                        next_event = next_event + 32'd1;
                        cur_chan = '0;
                        cur_samp = '0;
                        prs_phase = (cfg_samples == 16'd0) ? desc_pkg::PH_MARK
                                                           : desc_pkg::PH_SAMP;
                    end
                end
                default:
                    prs_phase = desc_pkg::PH_MARK;
            endcase
        end
        if (produced)
            pending_results.insert(pending_results.size(), r);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers backlog bytes, random idle cycles between words
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_if.valid     <= 1'b0;
            stream_if.data_byte <= '0;
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
            begin
                parse_byte(stream_if.data_byte);
                bytes_taken++;
            end
            if (!stream_if.valid || stream_if.ready)
            begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    stream_if.valid     <= 1'b1;
                    stream_if.data_byte <= byte_backlog.pop_front();
                end
                else
                    stream_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result words, compares with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: word %0d %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, words_checked, field, want, got);
        end
    endtask

    int  hold_left;
    bit  hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        desc_pkg::result_t want;
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                words_checked++;
                if (result_if.kind == desc_pkg::KIND_SAMPLE)
                    samples_seen++;
                else if (result_if.kind == desc_pkg::KIND_HEADER)
                    headers_seen++;
                else if (result_if.error_code == desc_pkg::ERR_RANGE)
                    range_seen++;
                else if (result_if.error_code == desc_pkg::ERR_MARKER)
                    marker_seen++;
                if (result_if.fatal)
                    fatal_code_seen = result_if.error_code;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected word: expected none, actual kind %0d code %0d",
                             $time, result_if.kind, result_if.error_code);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, result_if.kind);
                    check_field("error_code", want.error_code, result_if.error_code);
                    check_field("fatal", want.fatal, result_if.fatal);
                    check_field("event_number", want.event_number,
                                result_if.event_number);
                    check_field("time_stamp", want.time_stamp, result_if.time_stamp);
                    check_field("channel", want.channel, result_if.channel);
                    check_field("sample_index", want.sample_index,
                                result_if.sample_index);
                    check_field("sample_value", want.sample_value,
                                result_if.sample_value);
                    check_field("last_of_event", want.last_of_event,
                                result_if.last_of_event);
                end
            end
            // one long receiver stall so the two-word output stage fills and
            // back-pressures the byte input; otherwise random stalls
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (!hold_done && words_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d predictions outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            add_byte(w[8*k +: 8]);
        bytes_queued += 4;
    endtask

    function automatic logic [15:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (sample_plan.size() != 0)
            return sample_plan.pop_front();
        if (roll < 8)
            return 16'($urandom_range(65535, 16384));
        if (roll < 12)
            return roll[0] ? 16'h3FFF : 16'h0000;
        return 16'($urandom_range(16383));
    endfunction

    task automatic queue_sample(input logic [15:0] s);
        add_byte(s[7:0]);
        add_byte(s[15:8]);
        bytes_queued += 2;
    endtask

    // Well-formed header for the current registers, then n_samp samples
    task automatic send_event(input logic [31:0] stamp, input int n_samp);
        queue_word(desc_pkg::MARKER_WORD);
        queue_word(events_built);
        queue_word(stamp);
        queue_word(cfg_channels);
        queue_word({16'h0, cfg_samples});
        events_built = events_built + 32'd1;
        for (int k = 0; k < n_samp; k++)
            queue_sample(pick_sample());
    endtask

    // Wait until the block is idle: all bytes taken, all predictions matched,
    // then a settling wait for a byte that produced no result word
    task automatic settle();
        while (byte_backlog.size() != 0 || stream_if.valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [desc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == desc_pkg::CFG_CHANNELS_EXPECTED)
            cfg_channels = val;
        else
            cfg_samples = val[15:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned ff_run;
        int unsigned random_start;
        int unsigned ev;
        int unsigned fault_pick;
        logic [7:0]  b;
        logic [31:0] junk;

        clk = 1'b0;
        rst_n = 1'b0;
        stream_if.valid = 1'b0;
        stream_if.data_byte = '0;
        result_if.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        prs_phase = desc_pkg::PH_SYNC;
        sync_len = 0;
        hunt_count = 0;
        byte_idx = '0;
        word_acc = '0;
        next_event = '0;
        cur_stamp = '0;
        cur_chan = '0;
        cur_samp = '0;
        stopped = 1'b0;
        cfg_channels = desc_pkg::CHANNELS_RESET;
        cfg_samples = desc_pkg::SAMPLES_RESET;
        events_built = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // both registers at their extremes for the first event
        write_reg(desc_pkg::CFG_CHANNELS_EXPECTED, 32'hFFFF_FFFF);
        write_reg(desc_pkg::CFG_SAMPLES_PER_CHANNEL, 32'd0);

        // Sync hunt: noise with 0xFF runs of up to 19, then the real run of 20
        ff_run = 0;
        for (int k = 0; k < SYNC_NOISE; k++)
        begin
            b = ($urandom_range(99) < 30) ? desc_pkg::SYNC_BYTE : 8'($urandom_range(255));
            if (k == SYNC_NOISE - 1
                || (b == desc_pkg::SYNC_BYTE && ff_run == desc_pkg::SYNC_RUN_LEN - 1))
                b = 8'($urandom_range(254));
            ff_run = (b == desc_pkg::SYNC_BYTE) ? ff_run + 1 : 0;
            add_byte(b);
        end
        repeat (desc_pkg::SYNC_RUN_LEN) add_byte(desc_pkg::SYNC_BYTE);
        bytes_queued += SYNC_NOISE + desc_pkg::SYNC_RUN_LEN;

        // trailing 0xFF word and a marker one bit off: both flagged and skipped
        queue_word(32'hFFFF_FFFF);
        queue_word(desc_pkg::MARKER_WORD ^ 32'h0000_0001);

        // zero-length event: header word carries last_of_event
        send_event(32'h0000_0000, 0);
        settle();

        // one sample per channel, range edges on both sides of 16384
        write_reg(desc_pkg::CFG_CHANNELS_EXPECTED, 32'd0);
        write_reg(desc_pkg::CFG_SAMPLES_PER_CHANNEL, 32'd1);
        sample_plan = '{16'h0000, 16'h3FFF, 16'h4000, 16'hFFFF, 16'h2AAA, 16'h1555,
                        16'h8000};
        send_event(32'hFFFF_FFFF, NUM_CH);
        settle();

        // longest event length, cut short by a register write mid-event:
        // channel 0 is at index 3 when the length drops to 2, so it ends at once
        write_reg(desc_pkg::CFG_CHANNELS_EXPECTED, 32'(NUM_CH));
        write_reg(desc_pkg::CFG_SAMPLES_PER_CHANNEL, 32'd65535);
        send_event($urandom, 3);
        settle();
        write_reg(desc_pkg::CFG_SAMPLES_PER_CHANNEL, 32'd2);
        for (int k = 0; k < 1 + 2 * (NUM_CH - 1); k++)
            queue_sample(pick_sample());

        // Random part: mostly well-formed events with random content, with
        // junk words between events and occasional register changes
        random_start = bytes_queued;
        ev = 0;
        while (bytes_queued - random_start < RANDOM_BYTES)
        begin
            while (byte_backlog.size() > 48)
                @(negedge clk);
            if (ev == 8)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            else if (ev == 16)
            begin
                send_idle_pct = IDLE_PCT;
                take_idle_pct = IDLE_PCT;
            end
            if (ev != 0 && $urandom_range(2) == 0)
            begin
                settle();
                if ($urandom_range(1) == 0)
                    write_reg(desc_pkg::CFG_CHANNELS_EXPECTED,
                              ($urandom_range(2) == 0) ? $urandom : 32'(NUM_CH));
                write_reg(desc_pkg::CFG_SAMPLES_PER_CHANNEL,
                          ($urandom_range(7) == 0) ? $urandom_range(12, 6)
                                                   : $urandom_range(4));
            end
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    junk = ($urandom_range(1) == 0)
                         ? $urandom
                         : (desc_pkg::MARKER_WORD ^ (32'd1 << $urandom_range(31)));
                    if (junk == desc_pkg::MARKER_WORD)
                        junk = ~junk;
                    queue_word(junk);
                end
            end
            send_event($urandom, NUM_CH * int'(cfg_samples));
            ev++;
        end

        // sender pauses until everything is back, then one fatal header fault
        settle();
        fault_pick = $urandom_range(2);
        queue_word(desc_pkg::MARKER_WORD);
        if (fault_pick == 0)
            queue_word(events_built ^ (32'd1 << $urandom_range(31)));
        else
        begin
            queue_word(events_built);
            queue_word($urandom);
            if (fault_pick == 1)
                queue_word(cfg_channels ^ (32'd1 << $urandom_range(31)));
            else
            begin
                queue_word(cfg_channels);
                queue_word({16'h0, cfg_samples} ^ (32'd1 << $urandom_range(31)));
            end
        end
        // halted: these must be taken and produce nothing
        for (int k = 0; k < 12; k++)
            add_byte(8'($urandom_range(255)));
        bytes_queued += 12;

        while (byte_backlog.size() != 0 || stream_if.valid)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Covered: %0d bytes over %0d good events incl. sync hunt, zero and max",
                 bytes_taken, events_built);
        $display("  length, mid-event length change, long output stall, fatal header fault");
        $display("Checked %0d words: %0d headers, %0d samples, %0d range, %0d marker, fatal %0d",
                 words_checked, headers_seen, samples_seen, range_seen, marker_seen,
                 fatal_code_seen);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/desc_pkg.sv
design/desc_if.sv
design/daq_event_stream_checker.sv
design/desc_checker.sv
tb/sv/testbench.sv
